@@ src/hbs_pkg.sv @@
`timescale 1ns / 1ps

package hbs_pkg;

  // fixed field widths
  localparam int PIXEL_W      = 16;
  localparam int CHAN_W       = 8;
  localparam int BITS_W       = 6;
  localparam int COLUMN_W     = 7;
  localparam int ROW_ADDR_W   = 5;
  localparam int PLANE_W      = 3;
  localparam int DELAY_W      = 9;
  localparam int LANES        = 6;

  // configuration port
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BRIGHTNESS = 2'd0;

  // brightness value that bypasses scaling, also the reset value
  localparam logic [CHAN_W-1:0] BRIGHT_FULL = 8'd255;

  // channel selectors within one pixel
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } hbs_chan_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] top_pixel;
    logic [PIXEL_W-1:0] bottom_pixel;
  } hbs_in_t;

  typedef struct packed {
    logic [BITS_W-1:0]     plane_bits;
    logic [COLUMN_W-1:0]   column;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [PLANE_W-1:0]    plane_index;
    logic [DELAY_W-1:0]    enable_delay;
    logic                  plane_end;
    logic                  frame_end;
  } hbs_out_t;

  // scan position handed from the counters to the merge stage
  typedef struct packed {
    logic [COLUMN_W-1:0]   column;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [PLANE_W-1:0]    plane_index;
    logic                  plane_end;
    logic                  frame_end;
  } hbs_scan_t;

  // rgb565 channel widened to 8 bits by zero fill
  function automatic logic [CHAN_W-1:0] widen_channel(input logic [PIXEL_W-1:0] px,
                                                      input hbs_chan_t sel);
    logic [CHAN_W-1:0] c;
    case (sel)
      CH_RED:   c = {px[15:11], 3'b000};
      CH_GREEN: c = {px[10:5], 2'b00};
      CH_BLUE:  c = {px[4:0], 3'b000};
      default:  c = '0;
    endcase
    return c;
  endfunction

  // output enable hold count: 4 * 2^plane - 1
  function automatic logic [DELAY_W-1:0] enable_delay_of(input logic [PLANE_W-1:0] plane);
    logic [DELAY_W-1:0] d;
    d = (DELAY_W'(4) << plane) - DELAY_W'(1);
    return d;
  endfunction

endpackage

@@ src/hbs_lane.sv @@
`timescale 1ns / 1ps

module hbs_lane (
  input  logic [hbs_pkg::CHAN_W-1:0]  chan,
  input  logic [hbs_pkg::CHAN_W-1:0]  brightness,
  input  logic [hbs_pkg::PLANE_W-1:0] plane,
  output logic                        plane_bit
);
  import hbs_pkg::*;

  logic [2*CHAN_W-1:0] product;
  logic [CHAN_W-1:0]   scaled;

  // brightness scale, bypassed at full brightness
  assign product = chan * brightness;
  assign scaled  = (brightness == BRIGHT_FULL) ? chan : product[2*CHAN_W-1:CHAN_W];

  // bit of the current plane
  assign plane_bit = scaled[plane];

endmodule

@@ src/hbs_scan_counter.sv @@
`timescale 1ns / 1ps

module hbs_scan_counter #(
  parameter int PANEL_COLUMNS = 128,
  parameter int ROW_PAIRS     = 32,
  parameter int PLANES        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  output hbs_pkg::hbs_scan_t scan
);
  import hbs_pkg::*;

  localparam int COL_W = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
  localparam int ROW_W = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam int PLN_W = (PLANES > 1) ? $clog2(PLANES) : 1;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_PAIRS - 1);
  localparam logic [PLN_W-1:0] PLN_LAST = PLN_W'(PLANES - 1);

  logic [COL_W-1:0] column_r, column_nxt;
  logic [ROW_W-1:0] row_r,    row_nxt;
  logic [PLN_W-1:0] plane_r,  plane_nxt;
  logic             col_last, row_last, plane_last;

  assign col_last   = (column_r >= COL_LAST);
  assign row_last   = (row_r >= ROW_LAST);
  assign plane_last = (plane_r >= PLN_LAST);

  // column innermost, then plane, then row pair
  always_comb begin
    column_nxt = column_r;
    plane_nxt  = plane_r;
    row_nxt    = row_r;
    if (advance) begin
      if (!col_last) begin
        column_nxt = column_r + COL_W'(1);
      end else begin
        column_nxt = '0;
        if (!plane_last) begin
          plane_nxt = plane_r + PLN_W'(1);
        end else begin
          plane_nxt = '0;
          row_nxt   = row_last ? '0 : row_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      plane_r  <= '0;
      row_r    <= '0;
    end else begin
      column_r <= column_nxt;
      plane_r  <= plane_nxt;
      row_r    <= row_nxt;
    end
  end

  // position of the word now at the input
  assign scan.column      = COLUMN_W'(column_r);
  assign scan.row_address = ROW_ADDR_W'(row_r);
  assign scan.plane_index = PLANE_W'(plane_r);
  assign scan.plane_end   = col_last;
  assign scan.frame_end   = col_last && plane_last && row_last;

endmodule

@@ src/hub75_bcm_plane_scanner.sv @@
`timescale 1ns / 1ps

// HUB75 bit plane scanner: each input word is the top and bottom rgb565 pixel of the
// current column; each yields one output word with the six data bits of the current
// plane, the column, row pair address, plane index, output enable delay and the plane
// and frame end marks. The column counter advances on every accepted word, the plane
// and row pair counters when the counter inside them wraps. An accepted word is in
// the output register after the next edge; the six channel lanes (one 8x8 brightness
// multiply each) and the merge into that register are combinational, so one word is
// taken a cycle whenever the output side takes words. Brightness (register 0, reset
// 255) should be written only while no word is in flight.
module hub75_bcm_plane_scanner #(
  parameter int PANEL_COLUMNS = 128,
  parameter int ROW_PAIRS     = 32,
  parameter int PLANES        = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hbs_pkg::hbs_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hbs_pkg::hbs_out_t                   out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hbs_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import hbs_pkg::*;

  logic [CHAN_W-1:0] brightness_r, brightness_nxt;
  logic              cfg_write;
  logic              in_fire;
  hbs_scan_t         scan;
  logic [CHAN_W-1:0] chans [LANES];
  logic [LANES-1:0]  lane_bits;
  logic              out_valid_r, out_valid_nxt;
  hbs_out_t          out_data_r, out_data_nxt;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_BRIGHTNESS) ?
                      CFG_DATA_W'(brightness_r) : '0;

  always_comb begin
    brightness_nxt = brightness_r;
    if (cfg_write && (cfg_paddr == ADDR_BRIGHTNESS)) begin
      brightness_nxt = cfg_pwdata[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_FULL;
    end else begin
      brightness_r <= brightness_nxt;
    end
  end

  // take a word whenever the output register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  hbs_scan_counter #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .ROW_PAIRS     (ROW_PAIRS),
    .PLANES        (PLANES)
  ) u_counter (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_fire),
    .scan    (scan)
  );

  // widened channels, top pixel on lanes 0 to 2, bottom on 3 to 5
  always_comb begin
    chans[0] = widen_channel(in_data.top_pixel, CH_RED);
    chans[1] = widen_channel(in_data.top_pixel, CH_GREEN);
    chans[2] = widen_channel(in_data.top_pixel, CH_BLUE);
    chans[3] = widen_channel(in_data.bottom_pixel, CH_RED);
    chans[4] = widen_channel(in_data.bottom_pixel, CH_GREEN);
    chans[5] = widen_channel(in_data.bottom_pixel, CH_BLUE);
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hbs_lane u_lane (
      .chan       (chans[l]),
      .brightness (brightness_r),
      .plane      (scan.plane_index),
      .plane_bit  (lane_bits[l])
    );
  end

  // merge lane bits with the scan position
  always_comb begin
    out_data_nxt              = out_data_r;
    out_valid_nxt             = out_valid_r && !out_ready;
    if (in_fire) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.plane_bits   = lane_bits;
      out_data_nxt.column       = scan.column;
      out_data_nxt.row_address  = scan.row_address;
      out_data_nxt.plane_index  = scan.plane_index;
      out_data_nxt.enable_delay = enable_delay_of(scan.plane_index);
      out_data_nxt.plane_end    = scan.plane_end;
      out_data_nxt.frame_end    = scan.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a frame only ends on a latch point
  a_frame_on_plane_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.frame_end || out_data_r.plane_end))
    else $error("frame end without plane end");

  // an accepted word is in the output register next cycle
  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word lost");

  // delay tracks the plane of the same word
  a_delay_matches_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.enable_delay == enable_delay_of(out_data_r.plane_index)))
    else $error("enable delay does not match plane");

  // the column counter only moves when a word is taken
  a_counter_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(scan.column))
    else $error("column moved without a word");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import hbs_pkg::*;

  localparam int COLS            = 128;
  localparam int ROWS            = 32;
  localparam int PLANE_COUNT     = 8;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 165;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIR_ROWS        = 16;

  // one row of the directed table: pixel pair, and a typed result where it is obvious
  typedef struct packed {
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] bot;
    logic               typed;
    hbs_out_t           want;
  } dir_row_t;

  // first words after reset sit on plane 0 at full brightness, so no data bit can be set
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{16'hFFFF, 16'hFFFF, 1'b1, '{6'd0, 7'd0, 5'd0, 3'd0, 9'd3, 1'b0, 1'b0}},
    '{16'h0000, 16'h0000, 1'b1, '{6'd0, 7'd1, 5'd0, 3'd0, 9'd3, 1'b0, 1'b0}},
    '{16'hFFFF, 16'h0000, 1'b1, '{6'd0, 7'd2, 5'd0, 3'd0, 9'd3, 1'b0, 1'b0}},
    '{16'h0000, 16'hFFFF, 1'b1, '{6'd0, 7'd3, 5'd0, 3'd0, 9'd3, 1'b0, 1'b0}},
    '{16'hF800, 16'h07E0, 1'b0, '0},
    '{16'h001F, 16'hF800, 1'b0, '0},
    '{16'h07E0, 16'h001F, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, '0},
    '{16'h8410, 16'h7BEF, 1'b0, '0},
    '{16'h0821, 16'hF7DE, 1'b0, '0},
    '{16'h0020, 16'h0800, 1'b0, '0},
    '{16'h0001, 16'h8000, 1'b0, '0},
    '{16'h07FF, 16'hF81F, 1'b0, '0},
    '{16'hFFE0, 16'h001F, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 1'b0, '0}
  };

  // brightness of the first random phases, the rest are drawn
  localparam logic [CHAN_W-1:0] BRIGHT_SET [0:4] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  hbs_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  hbs_out_t              out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // typed result travelling with the word being offered
  logic                  typed_on;
  hbs_out_t              typed_word;

  // scan position and brightness as the block should hold them
  int                    col_m;
  int                    plane_m;
  int                    row_m;
  logic [CHAN_W-1:0]     bright_m;

  hbs_out_t              pending_q[$];
  int                    errors;
  int                    cycle_cnt;
  bit                    calm;

  hub75_bcm_plane_scanner #(
    .PANEL_COLUMNS(COLS),
    .ROW_PAIRS    (ROWS),
    .PLANES       (PLANE_COUNT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one widened channel, scaled, then the bit of the plane
  function automatic logic lane_bit(input logic [CHAN_W-1:0] c, input int plane);
    logic [2*CHAN_W-1:0] prod;
    logic [CHAN_W-1:0]   v;
    v = c;
    if (bright_m != BRIGHT_FULL) begin
      prod = c * bright_m;
      v = prod[2*CHAN_W-1:CHAN_W];
    end
    return v[plane];
  endfunction

  // r g b bits of one rgb565 pixel at the plane
  function automatic logic [2:0] pixel_lanes(input logic [PIXEL_W-1:0] px, input int plane);
    logic r;
    logic g;
    logic b;
    r = lane_bit({px[15:11], 3'b000}, plane);
    g = lane_bit({px[10:5], 2'b00}, plane);
    b = lane_bit({px[4:0], 3'b000}, plane);
    return {b, g, r};
  endfunction

  // result of a pixel pair at the current scan position
  function automatic hbs_out_t scan_predict(input hbs_in_t w);
    hbs_out_t r;
    logic     col_last;
    col_last       = (col_m >= COLS - 1);
    r.plane_bits   = {pixel_lanes(w.bottom_pixel, plane_m), pixel_lanes(w.top_pixel, plane_m)};
    r.column       = COLUMN_W'(col_m);
    r.row_address  = ROW_ADDR_W'(row_m);
    r.plane_index  = PLANE_W'(plane_m);
    r.enable_delay = DELAY_W'(4 * (1 << plane_m) - 1);
    r.plane_end    = col_last;
    r.frame_end    = col_last && (plane_m >= PLANE_COUNT - 1) && (row_m >= ROWS - 1);
    return r;
  endfunction

  // column, then plane, then row pair
  task automatic scan_advance();
    if (col_m < COLS - 1) begin
      col_m++;
    end else begin
      col_m = 0;
      if (plane_m < PLANE_COUNT - 1) begin
        plane_m++;
      end else begin
        plane_m = 0;
        row_m = (row_m < ROWS - 1) ? row_m + 1 : 0;
      end
    end
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // word monitor, predictor and scoreboard, plus the run limit
  always @(posedge clk) begin
    hbs_out_t want;
    cycle_cnt++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = scan_predict(in_data);
        if (typed_on)
          want = typed_word;
        scan_advance();
        pending_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_q.pop_front();
          report_field("plane_bits", int'(want.plane_bits), int'(out_data.plane_bits));
          report_field("column", int'(want.column), int'(out_data.column));
          report_field("row_address", int'(want.row_address), int'(out_data.row_address));
          report_field("plane_index", int'(want.plane_index), int'(out_data.plane_index));
          report_field("enable_delay", int'(want.enable_delay),
                       int'(out_data.enable_delay));
          report_field("plane_end", int'(want.plane_end), int'(out_data.plane_end));
          report_field("frame_end", int'(want.frame_end), int'(out_data.frame_end));
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: stall a drawn number of cycles before each word
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one word after a gap, return at the falling edge after it is taken
  task automatic send_word(input hbs_in_t w, input int gap, input logic typed,
                           input hbs_out_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    typed_on   <= typed;
    typed_word <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] a,
                            input logic [CFG_DATA_W-1:0] d, output logic [CFG_DATA_W-1:0] q);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    q = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_brightness();
    logic [CFG_DATA_W-1:0] q;
    apb_access(1'b0, ADDR_BRIGHTNESS, '0, q);
    if (q != CFG_DATA_W'(bright_m)) begin
      errors++;
      $display("%0t: brightness readback, expected %0d, actual %0d", $time, bright_m, q);
    end
  endtask

  // only once the pipeline has drained
  task automatic set_brightness(input logic [CHAN_W-1:0] v);
    logic [CFG_DATA_W-1:0] q;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    apb_access(1'b1, ADDR_BRIGHTNESS, CFG_DATA_W'(v), q);
    bright_m = v;
    check_brightness();
  endtask

  function automatic logic [PIXEL_W-1:0] draw_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    hbs_in_t w;
    int      gap;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    typed_on    = 1'b0;
    typed_word  = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    col_m       = 0;
    plane_m     = 0;
    row_m       = 0;
    bright_m    = BRIGHT_FULL;
    errors      = 0;
    cycle_cnt   = 0;
    calm        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_brightness();

    // directed table at reset brightness
    for (int i = 0; i < DIR_ROWS; i++) begin
      w.top_pixel    = DIR_TAB[i].top;
      w.bottom_pixel = DIR_TAB[i].bot;
      send_word(w, $urandom_range(0, 15), DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // random phases, together long enough to step through every plane
    for (int p = 0; p < PHASES; p++) begin
      set_brightness(p < 5 ? BRIGHT_SET[p] : CHAN_W'($urandom_range(0, 255)));
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k % 64 == 0)
          calm = ($urandom_range(0, 3) == 0);
        w.top_pixel    = draw_pixel();
        w.bottom_pixel = draw_pixel();
        gap = calm ? 0 : $urandom_range(0, 15);
        send_word(w, gap, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then give late words a chance to show
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
